>>> design/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// property checked at every clock edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("check failed");

`endif

>>> design/ctcf_pkg.sv
// ----------------------------------------------------------------------------
// ctcf_pkg
// Shared types, command codes and constants of the tilt filter core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctcf_pkg;

  // width of the step counter carried in a command
  localparam int ITER_W = 6;

  // datapath command codes
  localparam logic [3:0] OP_NOP         = 4'd0;
  localparam logic [3:0] OP_LOAD        = 4'd1;
  localparam logic [3:0] OP_CAL_ADD     = 4'd2;
  localparam logic [3:0] OP_DIV_START   = 4'd3;
  localparam logic [3:0] OP_DIV_STEP    = 4'd4;
  localparam logic [3:0] OP_DIV_STORE   = 4'd5;
  localparam logic [3:0] OP_SQ_A        = 4'd6;
  localparam logic [3:0] OP_SQ_B        = 4'd7;
  localparam logic [3:0] OP_ROOT_STEP   = 4'd8;
  localparam logic [3:0] OP_CORDIC_INIT = 4'd9;
  localparam logic [3:0] OP_CORDIC_STEP = 4'd10;
  localparam logic [3:0] OP_CORDIC_DONE = 4'd11;
  localparam logic [3:0] OP_MUL_GYRO    = 4'd12;
  localparam logic [3:0] OP_MUL_ACC     = 4'd13;
  localparam logic [3:0] OP_BLEND       = 4'd14;
  localparam logic [3:0] OP_OUT         = 4'd15;

  // selects: axis index for calibration, angle for the math path
  localparam logic [2:0] SEL_AX_X      = 3'd0;
  localparam logic [2:0] SEL_AX_Y      = 3'd1;
  localparam logic [2:0] SEL_AX_Z      = 3'd2;
  localparam logic [2:0] SEL_GY_X      = 3'd3;
  localparam logic [2:0] SEL_GY_Y      = 3'd4;
  localparam logic [2:0] SEL_PITCH     = 3'd0;
  localparam logic [2:0] SEL_ROLL      = 3'd1;
  localparam logic [2:0] SEL_INC_PITCH = 3'd5;
  localparam logic [2:0] SEL_INC_ROLL  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_GYRO_LSB = 2'd1;
  localparam logic [1:0] REG_ONE_G    = 2'd2;

  localparam logic [15:0] ALPHA_RESET    = 16'd62915;
  localparam logic [15:0] GYRO_LSB_RESET = 16'd131;
  localparam logic [14:0] ONE_G_RESET    = 15'd16384;
  localparam logic [19:0] US_PER_S       = 20'd1000000;

  // fixed unit sizes
  localparam int ROOT_STEPS  = 18;
  localparam int CORDIC_PRE  = 8;
  localparam int DEN_W       = 36;
  localparam int ROOT_W      = 36;
  localparam int CORDIC_W    = 28;
  localparam int ANGLE_Z_W   = 32;

  typedef struct packed {
    logic [3:0]        op;
    logic [2:0]        sel;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/ctcf_datapath.sv
// ----------------------------------------------------------------------------
// ctcf_datapath
// Registers and shared units: calibration sums, serial divider, serial
// square root, vectoring CORDIC, blend multipliers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctcf_datapath #(
  parameter int CALIBRATION_SAMPLES = 500,
  parameter int ANGLE_FRAC_BITS     = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  ctcf_pkg::cmd_t      cmd,
  output ctcf_pkg::stat_t     stat,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  gyro_x,
  input  logic signed [15:0]  gyro_y,
  input  logic [19:0]         elapsed_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [18:0]  pitch_angle,
  output logic signed [18:0]  roll_angle
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int NUM_W = 36 + F;
  localparam int DEN_W = ctcf_pkg::DEN_W;
  localparam int INC_W = 18 + F;
  localparam int SUM_W = 20 + F;
  localparam int ACC_W = 9 + F;
  localparam int P1_W  = SUM_W + 17;
  localparam int P2_W  = ACC_W + 18;
  localparam int BL_W  = P1_W + 1;
  localparam int RW    = ctcf_pkg::ROOT_W;
  localparam int CW    = ctcf_pkg::CORDIC_W;
  localparam int ZW    = ctcf_pkg::ANGLE_Z_W;
  localparam logic signed [BL_W-1:0] SAT_HI = BL_W'(262143);
  localparam logic signed [BL_W-1:0] SAT_LO = -BL_W'(262144);

  // configuration
  logic [15:0] gyro_weight;
  logic [15:0] gyro_lsb_per_dps;
  logic [14:0] accel_one_g;

  // sample registers
  logic signed [15:0] raw [5];
  logic signed [16:0] diff_x, diff_y, diff_z, diff_gx, diff_gy;
  logic [19:0]        us_reg;
  logic signed [24:0] axis_sums [5];
  logic signed [15:0] axis_offsets [5];

  // divider
  logic [DEN_W-1:0] rem, den;
  logic [NUM_W-1:0] quo;
  logic             neg;

  // square root
  logic [RW-1:0] n_reg, root, bitv;

  // cordic
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic                 czero;

  // angles and blend
  logic signed [ACC_W-1:0] acc_angle [2];
  logic signed [INC_W-1:0] inc_p, inc_r;
  logic signed [18:0]      pitch_state, roll_state;
  logic signed [P1_W-1:0]  p1;
  logic signed [P2_W-1:0]  p2;

  // combinational helpers
  logic [2:0]              sel_ix;
  logic signed [16:0]      rate;
  logic signed [37:0]      prod;
  logic signed [NUM_W:0]   num_s, num_mag;
  logic [15:0]             lsb_eff;
  logic [DEN_W:0]          trial;
  logic signed [NUM_W:0]   q_s;
  logic signed [17:0]      z_off;
  logic signed [15:0]      off_val;
  logic signed [16:0]      sq_in;
  logic signed [33:0]      sq_val;
  logic [RW-1:0]           rb;
  logic signed [17:0]      yv;
  logic [4:0]              ci;
  logic signed [CW-1:0]    dx, dy;
  logic signed [ZW-1:0]    at, zr, zsh;
  logic signed [SUM_W-1:0] gsum;
  logic signed [18:0]      st_sel;
  logic signed [INC_W-1:0] inc_sel;
  logic [16:0]             beta;
  logic signed [BL_W-1:0]  bsum, bsh;
  logic signed [18:0]      bsat;

  assign sel_ix = cmd.sel;

  always_comb begin
    // divider operand setup
    rate    = (cmd.sel == ctcf_pkg::SEL_INC_PITCH) ? diff_gy : diff_gx;
    prod    = rate * $signed({1'b0, us_reg});
    num_s   = (cmd.sel <= ctcf_pkg::SEL_GY_Y)
              ? (NUM_W+1)'(axis_sums[sel_ix])
              : ((NUM_W+1)'(prod) <<< F);
    num_mag = (num_s < 0) ? -num_s : num_s;
    lsb_eff = (gyro_lsb_per_dps == 16'd0) ? 16'd1 : gyro_lsb_per_dps;
    trial   = {rem, quo[NUM_W-1]};
    // quotient and offset
    q_s     = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    z_off   = $signed(18'(q_s)) - $signed({3'b000, accel_one_g});
    if (cmd.sel != ctcf_pkg::SEL_AX_Z) begin
      off_val = q_s[15:0];
    end else if (z_off > 18'sd32767) begin
      off_val = 16'sh7fff;
    end else if (z_off < -18'sd32768) begin
      off_val = -16'sd32768;
    end else begin
      off_val = z_off[15:0];
    end
    // square root
    sq_in   = (cmd.op == ctcf_pkg::OP_SQ_B) ? diff_z
              : ((cmd.sel == ctcf_pkg::SEL_PITCH) ? diff_x : diff_y);
    sq_val  = sq_in * sq_in;
    rb      = root + bitv;
    // cordic
    yv      = (cmd.sel == ctcf_pkg::SEL_PITCH) ? 18'(diff_y) : -18'(diff_x);
    ci      = cmd.iter[4:0];
    dx      = cx >>> ci;
    dy      = cy >>> ci;
    at      = $signed({2'b00, ctcf_pkg::atan_entry(ci)});
    zr      = cz + (ZW'(1) <<< (23 - F));
    zsh     = zr >>> (24 - F);
    // blend
    st_sel  = (cmd.sel == ctcf_pkg::SEL_PITCH) ? pitch_state : roll_state;
    inc_sel = (cmd.sel == ctcf_pkg::SEL_PITCH) ? inc_p : inc_r;
    gsum    = SUM_W'(st_sel) + SUM_W'(inc_sel);
    beta    = 17'h10000 - {1'b0, gyro_weight};
    bsum    = BL_W'(p1) + BL_W'(p2) + BL_W'(32768);
    bsh     = bsum >>> 16;
    if (bsh > SAT_HI) begin
      bsat = 19'sh3ffff;
    end else if (bsh < SAT_LO) begin
      bsat = -19'sd262144;
    end else begin
      bsat = bsh[18:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight      <= ctcf_pkg::ALPHA_RESET;
      gyro_lsb_per_dps <= ctcf_pkg::GYRO_LSB_RESET;
      accel_one_g      <= ctcf_pkg::ONE_G_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ctcf_pkg::REG_ALPHA:    gyro_weight      <= cfg_data;
        ctcf_pkg::REG_GYRO_LSB: gyro_lsb_per_dps <= cfg_data;
        ctcf_pkg::REG_ONE_G:    accel_one_g      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // filter state: sums, offsets, angles
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        axis_sums[i]    <= '0;
        axis_offsets[i] <= '0;
      end
      pitch_state <= '0;
      roll_state  <= '0;
    end else begin
      if (cmd.op == ctcf_pkg::OP_CAL_ADD) begin
        for (int i = 0; i < 5; i++) begin
          axis_sums[i] <= axis_sums[i] + 25'(raw[i]);
        end
      end
      if (cmd.op == ctcf_pkg::OP_DIV_STORE && cmd.sel <= ctcf_pkg::SEL_GY_Y) begin
        axis_offsets[sel_ix] <= off_val;
      end
      if (cmd.op == ctcf_pkg::OP_BLEND) begin
        if (cmd.sel == ctcf_pkg::SEL_PITCH) begin
          pitch_state <= bsat;
        end else begin
          roll_state <= bsat;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ctcf_pkg::OP_LOAD: begin
        raw[0]  <= accel_x;
        raw[1]  <= accel_y;
        raw[2]  <= accel_z;
        raw[3]  <= gyro_x;
        raw[4]  <= gyro_y;
        diff_x  <= 17'(accel_x) - 17'(axis_offsets[0]);
        diff_y  <= 17'(accel_y) - 17'(axis_offsets[1]);
        diff_z  <= 17'(accel_z) - 17'(axis_offsets[2]);
        diff_gx <= 17'(gyro_x) - 17'(axis_offsets[3]);
        diff_gy <= 17'(gyro_y) - 17'(axis_offsets[4]);
        us_reg  <= elapsed_us;
      end
      ctcf_pkg::OP_DIV_START: begin
        rem <= '0;
        quo <= num_mag[NUM_W-1:0];
        neg <= num_s < 0;
        if (cmd.sel <= ctcf_pkg::SEL_GY_Y) begin
          den <= DEN_W'(CALIBRATION_SAMPLES);
        end else begin
          den <= DEN_W'(lsb_eff) * DEN_W'(ctcf_pkg::US_PER_S);
        end
      end
      ctcf_pkg::OP_DIV_STEP: begin
        if (trial >= {1'b0, den}) begin
          rem <= DEN_W'(trial - {1'b0, den});
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
      end
      ctcf_pkg::OP_DIV_STORE: begin
        if (cmd.sel == ctcf_pkg::SEL_INC_PITCH) begin
          inc_p <= q_s[INC_W-1:0];
        end else if (cmd.sel == ctcf_pkg::SEL_INC_ROLL) begin
          inc_r <= q_s[INC_W-1:0];
        end
      end
      ctcf_pkg::OP_SQ_A: begin
        n_reg <= RW'(unsigned'(sq_val));
        root  <= '0;
        bitv  <= RW'(1) << 34;
      end
      ctcf_pkg::OP_SQ_B: begin
        n_reg <= n_reg + RW'(unsigned'(sq_val));
      end
      ctcf_pkg::OP_ROOT_STEP: begin
        if (n_reg >= rb) begin
          n_reg <= n_reg - rb;
          root  <= (root >> 1) + bitv;
        end else begin
          root  <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      ctcf_pkg::OP_CORDIC_INIT: begin
        cy    <= CW'(yv) <<< ctcf_pkg::CORDIC_PRE;
        cx    <= CW'({1'b0, root[17:0]}) <<< ctcf_pkg::CORDIC_PRE;
        cz    <= '0;
        czero <= (root == '0) && (yv == '0);
      end
      ctcf_pkg::OP_CORDIC_STEP: begin
        if (cy > 0) begin
          cx <= cx + dy;
          cy <= cy - dx;
          cz <= cz + at;
        end else begin
          cx <= cx - dy;
          cy <= cy + dx;
          cz <= cz - at;
        end
      end
      ctcf_pkg::OP_CORDIC_DONE: begin
        acc_angle[sel_ix[0]] <= czero ? '0 : zsh[ACC_W-1:0];
      end
      ctcf_pkg::OP_MUL_GYRO: begin
        p1 <= gsum * $signed({1'b0, gyro_weight});
      end
      ctcf_pkg::OP_MUL_ACC: begin
        p2 <= $signed({1'b0, beta}) * acc_angle[sel_ix[0]];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == ctcf_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ctcf_pkg::OP_OUT) begin
      pitch_angle <= pitch_state;
      roll_angle  <= roll_state;
    end
  end

  assign stat.out_full = out_valid;

endmodule

>>> design/ctcf_ctrl.sv
// ----------------------------------------------------------------------------
// ctcf_ctrl
// Sequencer: calibration counting and the step order of the angle math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctcf_ctrl #(
  parameter int CALIBRATION_SAMPLES = 500,
  parameter int ANGLE_FRAC_BITS     = 10,
  parameter int CORDIC_ITERATIONS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output ctcf_pkg::cmd_t  cmd,
  input  ctcf_pkg::stat_t stat
);

  localparam int NUM_W = 36 + ANGLE_FRAC_BITS;
  localparam int IW    = ctcf_pkg::ITER_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CAL_ADD   = 4'd1;
  localparam logic [3:0] S_DIV_START = 4'd2;
  localparam logic [3:0] S_DIV_STEP  = 4'd3;
  localparam logic [3:0] S_DIV_STORE = 4'd4;
  localparam logic [3:0] S_SQ_A      = 4'd5;
  localparam logic [3:0] S_SQ_B      = 4'd6;
  localparam logic [3:0] S_ROOT      = 4'd7;
  localparam logic [3:0] S_C_INIT    = 4'd8;
  localparam logic [3:0] S_C_STEP    = 4'd9;
  localparam logic [3:0] S_C_DONE    = 4'd10;
  localparam logic [3:0] S_MUL_G     = 4'd11;
  localparam logic [3:0] S_MUL_A     = 4'd12;
  localparam logic [3:0] S_BLEND     = 4'd13;
  localparam logic [3:0] S_OUT       = 4'd14;

  logic [3:0]    state, state_next;
  logic [2:0]    sel, sel_next;
  logic [IW-1:0] iter, iter_next;
  logic [8:0]    sample_count, sample_count_next;
  logic          calibrated, calibrated_next;
  logic          accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // command to the datapath
  always_comb begin
    cmd.sel  = sel;
    cmd.iter = iter;
    unique case (state)
      S_IDLE:      cmd.op = accept ? ctcf_pkg::OP_LOAD : ctcf_pkg::OP_NOP;
      S_CAL_ADD:   cmd.op = ctcf_pkg::OP_CAL_ADD;
      S_DIV_START: cmd.op = ctcf_pkg::OP_DIV_START;
      S_DIV_STEP:  cmd.op = ctcf_pkg::OP_DIV_STEP;
      S_DIV_STORE: cmd.op = ctcf_pkg::OP_DIV_STORE;
      S_SQ_A:      cmd.op = ctcf_pkg::OP_SQ_A;
      S_SQ_B:      cmd.op = ctcf_pkg::OP_SQ_B;
      S_ROOT:      cmd.op = ctcf_pkg::OP_ROOT_STEP;
      S_C_INIT:    cmd.op = ctcf_pkg::OP_CORDIC_INIT;
      S_C_STEP:    cmd.op = ctcf_pkg::OP_CORDIC_STEP;
      S_C_DONE:    cmd.op = ctcf_pkg::OP_CORDIC_DONE;
      S_MUL_G:     cmd.op = ctcf_pkg::OP_MUL_GYRO;
      S_MUL_A:     cmd.op = ctcf_pkg::OP_MUL_ACC;
      S_BLEND:     cmd.op = ctcf_pkg::OP_BLEND;
      S_OUT:       cmd.op = stat.out_full ? ctcf_pkg::OP_NOP : ctcf_pkg::OP_OUT;
      default:     cmd.op = ctcf_pkg::OP_NOP;
    endcase
  end

  // next state
  always_comb begin
    state_next        = state;
    sel_next          = sel;
    iter_next         = iter + IW'(1);
    sample_count_next = sample_count;
    calibrated_next   = calibrated;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          sel_next   = ctcf_pkg::SEL_PITCH;
          state_next = calibrated ? S_SQ_A : S_CAL_ADD;
        end
      end
      S_CAL_ADD: begin
        if (10'(sample_count) + 10'd1 >= 10'(CALIBRATION_SAMPLES)) begin
          sample_count_next = 9'(CALIBRATION_SAMPLES);
          sel_next          = ctcf_pkg::SEL_AX_X;
          state_next        = S_DIV_START;
        end else begin
          sample_count_next = sample_count + 9'd1;
          state_next        = S_IDLE;
        end
      end
      S_DIV_START: begin
        iter_next  = '0;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (iter == IW'(NUM_W - 1)) begin
          state_next = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        if (sel == ctcf_pkg::SEL_GY_Y) begin
          calibrated_next = 1'b1;
          state_next      = S_IDLE;
        end else if (sel == ctcf_pkg::SEL_INC_PITCH) begin
          sel_next   = ctcf_pkg::SEL_INC_ROLL;
          state_next = S_DIV_START;
        end else if (sel == ctcf_pkg::SEL_INC_ROLL) begin
          sel_next   = ctcf_pkg::SEL_PITCH;
          state_next = S_MUL_G;
        end else begin
          sel_next   = sel + 3'd1;
          state_next = S_DIV_START;
        end
      end
      S_SQ_A: state_next = S_SQ_B;
      S_SQ_B: begin
        iter_next  = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (iter == IW'(ctcf_pkg::ROOT_STEPS - 1)) begin
          state_next = S_C_INIT;
        end
      end
      S_C_INIT: begin
        iter_next  = '0;
        state_next = S_C_STEP;
      end
      S_C_STEP: begin
        if (iter == IW'(CORDIC_ITERATIONS - 1)) begin
          state_next = S_C_DONE;
        end
      end
      S_C_DONE: begin
        if (sel == ctcf_pkg::SEL_PITCH) begin
          sel_next   = ctcf_pkg::SEL_ROLL;
          state_next = S_SQ_A;
        end else begin
          sel_next   = ctcf_pkg::SEL_INC_PITCH;
          state_next = S_DIV_START;
        end
      end
      S_MUL_G: state_next = S_MUL_A;
      S_MUL_A: state_next = S_BLEND;
      S_BLEND: begin
        if (sel == ctcf_pkg::SEL_PITCH) begin
          sel_next   = ctcf_pkg::SEL_ROLL;
          state_next = S_MUL_G;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_full) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sel          <= '0;
      iter         <= '0;
      sample_count <= '0;
      calibrated   <= 1'b0;
    end else begin
      state        <= state_next;
      sel          <= sel_next;
      iter         <= iter_next;
      sample_count <= sample_count_next;
      calibrated   <= calibrated_next;
    end
  end

endmodule

>>> design/calibrated_tilt_complementary_filter_core.sv
// ----------------------------------------------------------------------------
// calibrated_tilt_complementary_filter_core
// Pitch and roll complementary filter with start-up offset calibration.
// ----------------------------------------------------------------------------
// The first CALIBRATION_SAMPLES beats only build per-axis sums and return no
// result; after the last one the offsets come out of the shared serial
// divider. Every later beat returns one result, worked out by two 18-step
// square roots, two CORDIC runs of one iteration per cycle and two gyro
// divisions of one quotient bit per cycle. One beat is worked on at a time; a
// new beat is taken while the previous result still waits on the output.
`timescale 1ns / 1ps

module calibrated_tilt_complementary_filter_core #(
  parameter int CALIBRATION_SAMPLES = 500,
  parameter int ANGLE_FRAC_BITS     = 10,
  parameter int CORDIC_ITERATIONS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic [19:0]        elapsed_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] pitch_angle,
  output logic signed [18:0] roll_angle
);

  ctcf_pkg::cmd_t  cmd;
  ctcf_pkg::stat_t stat;

  // sequencer
  ctcf_ctrl #(
    .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES),
    .ANGLE_FRAC_BITS     (ANGLE_FRAC_BITS),
    .CORDIC_ITERATIONS   (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // arithmetic and storage
  ctcf_datapath #(
    .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES),
    .ANGLE_FRAC_BITS     (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .gyro_x      (gyro_x),
    .gyro_y      (gyro_y),
    .elapsed_us  (elapsed_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle)
  );

endmodule

>>> design/ctcf_checker.sv
// ----------------------------------------------------------------------------
// ctcf_checker
// Port-level checks of the tilt filter core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctcf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [18:0] pitch_angle
);

  // a held result beat stays offered
  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)
  // a held result beat keeps its payload
  `CHK_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(pitch_angle))
  // a taken input beat keeps the block busy in the next cycle
  `CHK_ASSERT(a_busy_after_take, clk, rst, in_valid && !in_stall |=> in_stall)
  // a new result only appears at the end of busy work
  `CHK_ASSERT(a_result_from_work, clk, rst, $rose(out_valid) |-> $past(in_stall))
  // reset leaves no result on offer
  `CHK_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid)

endmodule

bind calibrated_tilt_complementary_filter_core ctcf_checker u_ctcf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pitch_angle (pitch_angle)
);

>>> test/tb_calibrated_tilt_complementary_filter_core.sv
// ----------------------------------------------------------------------------
// tb_calibrated_tilt_complementary_filter_core
// Self-checking bench for the calibrated tilt filter. It runs the start-up
// calibration, then directed and random samples under several coefficient
// settings. Both handshakes idle at random, and one long output hold-off
// backs the core up. Each beat is predicted and then compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calibrated_tilt_complementary_filter_core;

  localparam int CAL_COUNT   = 500;
  localparam int FRAC_BITS   = 10;
  localparam int CORDIC_ITER = 16;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy;
    logic [19:0]        us;
  } imu_sample_t;

  // tilt predictor plus store of expected angle pairs
  class tilt_scoreboard;
    longint alpha = 62915, lsb = 131, one_g = 16384;
    int     cal_seen = 0;
    bit     cal_done = 0;
    longint sums[5], ofs[5];
    longint pitch = 0, roll = 0;
    logic signed [18:0] exp_pitch[$], exp_roll[$];
    int     mismatches = 0;
    longint atan_deg[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335};

    function new();
      foreach (sums[i]) begin
        sums[i] = 0;
        ofs[i]  = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        ctcf_pkg::REG_ALPHA:    alpha = longint'(data);
        ctcf_pkg::REG_GYRO_LSB: lsb   = longint'(data);
        ctcf_pkg::REG_ONE_G:    one_g = longint'(data[14:0]);
        default: ;
      endcase
    endfunction

    function longint root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    // vectoring rotation, angle in 1/1024 degree
    function longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < CORDIC_ITER; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y > 0) begin
          x = x + dy; y = y - dx; z = z + atan_deg[i];
        end else begin
          x = x - dy; y = y + dx; z = z - atan_deg[i];
        end
      end
      return (z + (64'sd1 <<< (23 - FRAC_BITS))) >>> (24 - FRAC_BITS);
    endfunction

    function longint rate_step(longint rate, longint us);
      longint d;
      d = (lsb == 0 ? 1 : lsb) * 1000000;
      return rate * us * (64'sd1 <<< FRAC_BITS) / d;
    endfunction

    function longint mix(longint old, longint inc, longint acc);
      longint s;
      s = (alpha * (old + inc) + (65536 - alpha) * acc + 32768) >>> 16;
      if (s < -262144) s = -262144;
      if (s > 262143) s = 262143;
      return s;
    endfunction

    // accepted input beat: calibrate or predict
    function void note_input(imu_sample_t s);
      longint v[5], ax, ay, az, ap, ar;
      v[0] = longint'(s.ax); v[1] = longint'(s.ay); v[2] = longint'(s.az);
      v[3] = longint'(s.gx); v[4] = longint'(s.gy);
      if (!cal_done) begin
        foreach (v[i]) sums[i] += v[i];
        cal_seen++;
        if (cal_seen >= CAL_COUNT) begin
          foreach (v[i]) ofs[i] = sums[i] / CAL_COUNT;
          ofs[2] = ofs[2] - one_g;
          if (ofs[2] < -32768) ofs[2] = -32768;
          if (ofs[2] > 32767) ofs[2] = 32767;
          cal_done = 1;
        end
        return;
      end
      ax = v[0] - ofs[0];
      ay = v[1] - ofs[1];
      az = v[2] - ofs[2];
      ap = vector_angle(ay, root_floor(ax * ax + az * az));
      ar = vector_angle(-ax, root_floor(ay * ay + az * az));
      pitch = mix(pitch, rate_step(v[4] - ofs[4], longint'(s.us)), ap);
      roll  = mix(roll, rate_step(v[3] - ofs[3], longint'(s.us)), ar);
      exp_pitch.push_back(pitch[18:0]);
      exp_roll.push_back(roll[18:0]);
    endfunction

    function void check_result(logic signed [18:0] p, logic signed [18:0] r);
      logic signed [18:0] ep, er;
      if (exp_pitch.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: pitch %0d roll %0d", p, r);
        return;
      end
      ep = exp_pitch.pop_front();
      er = exp_roll.pop_front();
      if (p !== ep || r !== er) begin
        mismatches++;
        if (mismatches <= 10)
          $display("angle mismatch: pitch exp %0d got %0d, roll exp %0d got %0d",
                   ep, p, er, r);
      end
    endfunction

    function int pending();
      return exp_pitch.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, gyro_x = '0, gyro_y = '0;
  logic [19:0] elapsed_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [18:0] pitch_angle, roll_angle;

  tilt_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;

  calibrated_tilt_complementary_filter_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .pitch_angle(pitch_angle), .roll_angle(roll_angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end
      out_stall <= (!calm && $urandom_range(99) < 17);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(pitch_angle, roll_angle);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // offer one beat and hold it until accepted; called at a clock edge
  task automatic send_sample(imu_sample_t s);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    accel_x    <= s.ax;
    accel_y    <= s.ay;
    accel_z    <= s.az;
    gyro_x     <= s.gx;
    gyro_y     <= s.gy;
    elapsed_us <= s.us;
    do @(posedge clk); while (in_stall);
    sb.note_input(s);
  endtask

  task automatic send_fields(longint ax, longint ay, longint az, longint gx, longint gy,
                             longint us);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.us = 20'(us);
    send_sample(s);
  endtask

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
    s.gx = 16'($urandom); s.gy = 16'($urandom); s.us = 20'($urandom);
    // mostly sensor-like motion, the rest full-range noise
    if ($urandom_range(99) < 70) begin
      s.ax = $signed(16'($urandom_range(8000))) - 16'sd4000 + 16'(sb.ofs[0]);
      s.ay = $signed(16'($urandom_range(8000))) - 16'sd4000 + 16'(sb.ofs[1]);
      s.gx = $signed(16'($urandom_range(4000))) - 16'sd2000;
      s.gy = $signed(16'($urandom_range(4000))) - 16'sd2000;
      s.us = 20'($urandom_range(40000));
    end
    return s;
  endfunction

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    imu_sample_t s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_UNUSED, 16'hffff);
    write_reg(ctcf_pkg::REG_ONE_G, 16'd32767);

    // calibration beats; z held low so its offset saturates
    @(posedge clk);
    for (int i = 0; i < CAL_COUNT; i++) begin
      s = random_sample();
      s.ax = 16'($urandom); s.ay = 16'($urandom);
      s.gx = 16'($urandom); s.gy = 16'($urandom);
      s.az = -16'sd32768 + 16'($urandom_range(2768));
      send_sample(s);
    end
    in_valid <= 1'b0;
    repeat (2000) @(posedge clk);
    write_reg(ctcf_pkg::REG_ONE_G, 16'd1);
    write_reg(ctcf_pkg::REG_ALPHA, 16'd62915);
    write_reg(ctcf_pkg::REG_GYRO_LSB, 16'd131);

    // directed corners
    @(posedge clk);
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(32767, 32767, 32767, 32767, 32767, 20'hfffff);
    send_fields(-32768, -32768, -32768, -32768, -32768, 20'hfffff);
    send_fields(sb.ofs[0], sb.ofs[1], sb.ofs[2], 32767, -32768, 20'hfffff);
    send_fields(sb.ofs[0], sb.ofs[1], sb.ofs[2], 0, 0, 0);
    send_fields(32767, sb.ofs[1], sb.ofs[2], -32768, 32767, 1000);
    send_fields(-32768, sb.ofs[1], sb.ofs[2], 100, -100, 20000);
    send_fields(sb.ofs[0], 32767, sb.ofs[2], 0, 0, 20000);
    send_fields(sb.ofs[0], -32768, sb.ofs[2], 0, 0, 20000);
    send_fields(sb.ofs[0], sb.ofs[1], 32767, 131, 131, 1000000);
    send_fields(sb.ofs[0], sb.ofs[1], -32768, -131, -131, 1000000);
    send_fields(1, -1, 1, 1, -1, 1);
    in_valid <= 1'b0;
    settle();

    // random phases under different coefficients
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(ctcf_pkg::REG_ALPHA, 16'd0);
          write_reg(ctcf_pkg::REG_GYRO_LSB, 16'd1);
        end
        1: begin
          write_reg(ctcf_pkg::REG_ALPHA, 16'hffff);
          write_reg(ctcf_pkg::REG_GYRO_LSB, 16'hffff);
        end
        2: begin
          write_reg(ctcf_pkg::REG_ALPHA, 16'd62915);
          write_reg(ctcf_pkg::REG_GYRO_LSB, 16'd131);
        end
        default: begin
          write_reg(ctcf_pkg::REG_ALPHA, 16'($urandom));
          write_reg(ctcf_pkg::REG_GYRO_LSB, 16'($urandom_range(65535, 1)));
          write_reg(ctcf_pkg::REG_ONE_G, 16'($urandom));
        end
      endcase
      @(posedge clk);
      for (int i = 0; i < 350; i++) begin
        calm = (ph == 2 && i >= 100 && i < 250);
        if (ph == 1 && i == 50) hold_req = 1;
        send_sample(random_sample());
      end
      calm = 0;
      in_valid <= 1'b0;
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("calibrated_tilt_complementary_filter_core regression: pass");
    end else begin
      $display("calibrated_tilt_complementary_filter_core regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("calibrated_tilt_complementary_filter_core regression: fail");
    $finish;
  end

endmodule
